@@ rtl/core/lcdnw_pkg.sv @@
`default_nettype none

package lcdnw_pkg;

    // Request kinds
    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_CMD  = 2'd1;
    localparam logic [1:0] REQ_DATA = 2'd2;
    localparam logic [1:0] REQ_NUM  = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_GAP   = 2'd1;

    localparam logic [7:0] PULSE_HOLD_RST = 8'd5;
    localparam logic [7:0] INIT_GAP_RST   = 8'd2;

    // Number display limits
    localparam int unsigned MAX_DIGITS = 5;
    localparam int unsigned MIN_DIGITS = 2;
    localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);
    localparam int unsigned POW_W      = 17;

    // Init sequence
    localparam int unsigned INIT_CMD_N = 5;
    localparam int unsigned INIT_IDX_W = $clog2(INIT_CMD_N);

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] ZERO_CHAR = 8'h30;

    // Byte source for the word being sent
    localparam logic [1:0] SEL_INIT  = 2'd0;
    localparam logic [1:0] SEL_REQ   = 2'd1;
    localparam logic [1:0] SEL_DOT   = 2'd2;
    localparam logic [1:0] SEL_DIGIT = 2'd3;

    localparam logic [1:0] PHASE_LAST = 2'd3;

    typedef struct packed {
        logic                  accept;
        logic                  clamp;
        logic                  sub;
        logic                  clr_digit;
        logic                  emit;
        logic                  last;
        logic [1:0]            sel;
        logic [1:0]            phase;
        logic [INIT_IDX_W-1:0] init_idx;
        logic [DIG_IDX_W-1:0]  pos;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [DIG_IDX_W-1:0] n_m1;
        logic                 dot;
        logic                 ge_div;
        logic                 out_free;
    } t_dp_sts;

    function automatic logic [7:0] init_cmd(input logic [INIT_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h0E;
            3'd2:    c = 8'h06;
            3'd3:    c = 8'h01;
            3'd4:    c = 8'h0C;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [POW_W-1:0] pow10(input logic [DIG_IDX_W:0] e);
        logic [POW_W-1:0] p;
        case (e)
            4'd0:    p = 17'd1;
            4'd1:    p = 17'd10;
            4'd2:    p = 17'd100;
            4'd3:    p = 17'd1000;
            4'd4:    p = 17'd10000;
            4'd5:    p = 17'd100000;
            default: p = 17'd100000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/lcdnw_ctrl.sv @@
`default_nettype none

module lcdnw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lcdnw_pkg::t_dp_sts i_sts,
    output lcdnw_pkg::t_dp_cmd      o_cmd
);
    import lcdnw_pkg::*;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_NUM_SET  = 2'd1;
    localparam logic [1:0] S_DIG_CALC = 2'd2;
    localparam logic [1:0] S_SEND     = 2'd3;

    logic [1:0]            r_state, n_state;
    logic [1:0]            r_phase, n_phase;
    logic [1:0]            r_sel, n_sel;
    logic [INIT_IDX_W-1:0] r_init_idx, n_init_idx;
    logic [DIG_IDX_W-1:0]  r_pos, n_pos;

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence requests: one pin state per cycle while the output register is free
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_sel      = r_sel;
        n_init_idx = r_init_idx;
        n_pos      = r_pos;

        o_cmd           = '0;
        o_cmd.sel       = r_sel;
        o_cmd.phase     = r_phase;
        o_cmd.init_idx  = r_init_idx;
        o_cmd.pos       = r_pos;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_phase      = 2'd0;
                    n_init_idx   = '0;
                    n_state      = S_SEND;
                    n_sel        = SEL_REQ;
                    if (i_sts.req_type == REQ_INIT) begin
                        n_sel = SEL_INIT;
                    end else if (i_sts.req_type == REQ_NUM) begin
                        n_state = S_NUM_SET;
                    end
                end
            end
            S_NUM_SET: begin
                o_cmd.clamp     = 1'b1;
                o_cmd.clr_digit = 1'b1;
                n_pos           = i_sts.n_m1;
                n_state         = S_DIG_CALC;
            end
            S_DIG_CALC: begin
                if (i_sts.ge_div) begin
                    o_cmd.sub = 1'b1;
                end else begin
                    n_state = S_SEND;
                    n_phase = 2'd0;
                    n_sel   = (r_pos == '0 && i_sts.dot) ? SEL_DOT : SEL_DIGIT;
                end
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_phase    = r_phase + 2'd1;
                    if (r_phase == PHASE_LAST) begin
                        case (r_sel)
                            SEL_INIT: begin
                                if (r_init_idx == INIT_IDX_W'(INIT_CMD_N - 1)) begin
                                    o_cmd.last = 1'b1;
                                    n_state    = S_IDLE;
                                end else begin
                                    n_init_idx = r_init_idx + 1'b1;
                                end
                            end
                            SEL_REQ: begin
                                o_cmd.last = 1'b1;
                                n_state    = S_IDLE;
                            end
                            SEL_DOT: begin
                                n_sel = SEL_DIGIT;
                            end
                            SEL_DIGIT: begin
                                if (r_pos == '0) begin
                                    o_cmd.last = 1'b1;
                                    n_state    = S_IDLE;
                                end else begin
                                    n_pos           = r_pos - 1'b1;
                                    o_cmd.clr_digit = 1'b1;
                                    n_state         = S_DIG_CALC;
                                end
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_phase    <= n_phase;
        r_sel      <= n_sel;
        r_init_idx <= n_init_idx;
        r_pos      <= n_pos;
    end

endmodule

`default_nettype wire

@@ rtl/core/lcdnw_dp.sv @@
`default_nettype none

module lcdnw_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire lcdnw_pkg::t_dp_cmd              i_cmd,
    output lcdnw_pkg::t_dp_sts                   o_sts,
    input  wire logic                            i_cfg_valid,
    input  wire logic [lcdnw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [7:0]                      i_byte_value,
    input  wire logic [15:0]                     i_number_value,
    input  wire logic [2:0]                      i_digit_count,
    input  wire logic                            i_decimal_point,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [3:0]                           o_bus_nibble,
    output logic                                 o_reg_select,
    output logic                                 o_enable,
    output logic [8:0]                           o_hold_ms,
    output logic                                 o_overflow,
    output logic                                 o_last
);
    import lcdnw_pkg::*;

    logic [7:0]           r_pulse_hold;
    logic [7:0]           r_init_gap;
    logic [1:0]           r_req_type;
    logic [7:0]           r_byte;
    logic [15:0]          r_rem;
    logic [2:0]           r_count;
    logic                 r_dot;
    logic                 r_ovf;
    logic [3:0]           r_digit;

    logic                 r_out_valid;
    logic [3:0]           r_out_nibble;
    logic                 r_out_rs;
    logic                 r_out_en;
    logic [8:0]           r_out_hold;
    logic                 r_out_ovf;
    logic                 r_out_last;

    logic [DIG_IDX_W-1:0] n_m1;
    logic [POW_W-1:0]     limit;
    logic [POW_W-1:0]     divisor;
    logic                 too_big;
    logic [7:0]           cur_byte;
    logic [8:0]           hold;

    // Clamp the digit count to the supported range
    always_comb begin
        if (r_count < 3'(MIN_DIGITS)) begin
            n_m1 = DIG_IDX_W'(MIN_DIGITS - 1);
        end else if (r_count > 3'(MAX_DIGITS)) begin
            n_m1 = DIG_IDX_W'(MAX_DIGITS - 1);
        end else begin
            n_m1 = DIG_IDX_W'(r_count - 3'd1);
        end
    end

    assign limit   = pow10({1'b0, n_m1} + 1'b1);
    assign divisor = pow10({1'b0, i_cmd.pos});
    assign too_big = {1'b0, r_rem} >= limit;

    assign o_sts.req_type = i_req_type;
    assign o_sts.n_m1     = n_m1;
    assign o_sts.dot      = r_dot;
    assign o_sts.ge_div   = {1'b0, r_rem} >= divisor;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_hold <= PULSE_HOLD_RST;
            r_init_gap   <= INIT_GAP_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PULSE_HOLD) begin
                r_pulse_hold <= i_cfg_data;
            end else if (i_cfg_index == CFG_INIT_GAP) begin
                r_init_gap <= i_cfg_data;
            end
        end
    end

    // Latch the request, clamp the number, peel digits by repeated subtraction
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_type <= i_req_type;
            r_byte     <= i_byte_value;
            r_rem      <= i_number_value;
            r_count    <= i_digit_count;
            r_dot      <= i_decimal_point;
            r_ovf      <= 1'b0;
        end else if (i_cmd.clamp) begin
            r_ovf <= too_big;
            if (too_big) begin
                r_rem <= 16'(limit - 1'b1);
            end
        end else if (i_cmd.sub) begin
            r_rem <= r_rem - divisor[15:0];
        end
        if (i_cmd.clr_digit) begin
            r_digit <= 4'd0;
        end else if (i_cmd.sub) begin
            r_digit <= r_digit + 4'd1;
        end
    end

    // Pick the byte being sent
    always_comb begin
        case (i_cmd.sel)
            SEL_INIT:  cur_byte = init_cmd(i_cmd.init_idx);
            SEL_REQ:   cur_byte = r_byte;
            SEL_DOT:   cur_byte = DOT_CHAR;
            SEL_DIGIT: cur_byte = ZERO_CHAR + {4'd0, r_digit};
            default:   cur_byte = r_byte;
        endcase
    end

    // Init commands get the extra gap on their final phase
    assign hold = (i_cmd.sel == SEL_INIT && i_cmd.phase == PHASE_LAST)
                ? {1'b0, r_pulse_hold} + {1'b0, r_init_gap}
                : {1'b0, r_pulse_hold};

    // Output register: load a new word, or drop the old one once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out_nibble <= i_cmd.phase[1] ? cur_byte[3:0] : cur_byte[7:4];
            r_out_rs     <= (r_req_type == REQ_DATA) || (r_req_type == REQ_NUM);
            r_out_en     <= !i_cmd.phase[0];
            r_out_hold   <= hold;
            r_out_ovf    <= r_ovf;
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bus_nibble = r_out_nibble;
    assign o_reg_select = r_out_rs;
    assign o_enable     = r_out_en;
    assign o_hold_ms    = r_out_hold;
    assign o_overflow   = r_out_ovf;
    assign o_last       = r_out_last;

endmodule

`default_nettype wire

@@ rtl/core/char_lcd_nibble_writer_core.sv @@
`default_nettype none

// Character LCD writer for a 4-bit bus. Each accepted request (init sequence,
// command byte, data byte or decimal number) becomes a stream of output words,
// one per held pin state: every byte goes out as high nibble then low nibble,
// each shown with enable high and then enable low, and the final word of a
// request carries o_last. The block takes one request at a time and issues one
// word per cycle while the output register is free and no digit is being
// computed. A number first has its digit count and value clamped, then each of
// up to five digits is found by repeated subtraction of a power of ten (the
// digit value is the count of subtractions) and sent, the dot before the last.
// Configuration writes are always taken (o_cfg_ready is tied high) and must
// only arrive while no request is in flight.
module char_lcd_nibble_writer_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lcdnw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [7:0]                      i_byte_value,
    input  wire logic [15:0]                     i_number_value,
    input  wire logic [2:0]                      i_digit_count,
    input  wire logic                            i_decimal_point,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [3:0]                           o_bus_nibble,
    output logic                                 o_reg_select,
    output logic                                 o_enable,
    output logic [8:0]                           o_hold_ms,
    output logic                                 o_overflow,
    output logic                                 o_last
);
    import lcdnw_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    lcdnw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lcdnw_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req_type),
        .i_byte_value    (i_byte_value),
        .i_number_value  (i_number_value),
        .i_digit_count   (i_digit_count),
        .i_decimal_point (i_decimal_point),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_bus_nibble    (o_bus_nibble),
        .o_reg_select    (o_reg_select),
        .o_enable        (o_enable),
        .o_hold_ms       (o_hold_ms),
        .o_overflow      (o_overflow),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

@@ rtl/core/lcdnw_chk.sv @@
`default_nettype none

module lcdnw_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [3:0] o_bus_nibble,
    input wire logic       o_enable,
    input wire logic [8:0] o_hold_ms,
    input wire logic       o_last
);

    // A stalled output word holds its pins
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_bus_nibble) && $stable(o_enable) && $stable(o_last))
        else $error("output word changed while stalled");

    // A request in progress blocks the next one
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after a request");

    // Every request ends on an enable-low phase
    a_last_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> !o_enable)
        else $error("last word has enable high");

    // Enable-high phases hold under 256, which only the init gap can exceed
    a_high_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_enable |-> !o_hold_ms[8])
        else $error("enable-high phase held too long");

endmodule

bind char_lcd_nibble_writer_core lcdnw_chk u_lcdnw_chk (.*);

`default_nettype wire

@@ tb/char_lcd_nibble_writer_core_tb.sv @@
`timescale 1ns / 1ps

module char_lcd_nibble_writer_core_tb;

    import lcdnw_pkg::*;

    // Spare register indexes: writes there must leave both registers alone
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

    localparam logic [7:0] LCD_INIT_SEQ [5] = '{8'h28, 8'h0E, 8'h06, 8'h01, 8'h0C};

    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] num;
        logic [2:0]  digits;
        logic        dot;
    } lcd_req_t;

    typedef struct {
        logic [3:0] nibble;
        logic       rs;
        logic       en;
        logic [8:0] hold;
        logic       ovf;
        logic       last;
    } lcd_pin_word_t;

    // Predicted pin states, held in arrival order
    class lcd_scoreboard;
        lcd_pin_word_t pin_q[$];
        logic [7:0]    pulse_ms;
        logic [7:0]    gap_ms;
        int unsigned   fails;

        function new();
            pulse_ms = PULSE_HOLD_RST;
            gap_ms   = INIT_GAP_RST;
            fails    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == CFG_PULSE_HOLD) begin
                pulse_ms = val;
            end else if (idx == CFG_INIT_GAP) begin
                gap_ms = val;
            end
        endfunction

        // Queue the four pin states of one byte: high nibble, then low
        function void push_byte(logic [7:0] b, logic rs, logic [7:0] extra, logic ovf);
            lcd_pin_word_t w;
            int k;
            for (k = 0; k < 4; k++) begin
                w.nibble = (k < 2) ? b[7:4] : b[3:0];
                w.rs     = rs;
                w.en     = (k % 2 == 0);
                w.hold   = {1'b0, pulse_ms} + ((k == 3) ? {1'b0, extra} : 9'd0);
                w.ovf    = ovf;
                w.last   = 1'b0;
                pin_q.push_back(w);
            end
        endfunction

        function void note_request(lcd_req_t r);
            int unsigned n;
            int unsigned span;
            int unsigned rest;
            int unsigned place;
            int unsigned dg;
            int          k;
            logic        ovf;
            ovf = 1'b0;
            case (r.kind)
                REQ_INIT: begin
                    for (k = 0; k < 5; k++) push_byte(LCD_INIT_SEQ[k], 1'b0, gap_ms, 1'b0);
                end
                REQ_CMD:  push_byte(r.data_byte, 1'b0, 8'd0, 1'b0);
                REQ_DATA: push_byte(r.data_byte, 1'b1, 8'd0, 1'b0);
                default: begin
                    // Clamp the digit count, then the value to all nines
                    n = r.digits;
                    if (n < MIN_DIGITS) n = MIN_DIGITS;
                    if (n > MAX_DIGITS) n = MAX_DIGITS;
                    span = 1;
                    for (k = 0; k < n; k++) span = span * 10;
                    rest = r.num;
                    if (rest >= span) begin
                        ovf  = 1'b1;
                        rest = span - 1;
                    end
                    place = span / 10;
                    for (k = 0; k < n; k++) begin
                        dg    = rest / place;
                        rest  = rest % place;
                        if (place >= 10) place = place / 10;
                        if (k == n - 1 && r.dot) push_byte(DOT_CHAR, 1'b1, 8'd0, ovf);
                        push_byte(ZERO_CHAR + 8'(dg), 1'b1, 8'd0, ovf);
                    end
                end
            endcase
            pin_q[pin_q.size() - 1].last = 1'b1;
        endfunction

        function bit field_ok(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_word(lcd_pin_word_t got);
            lcd_pin_word_t want;
            bit            ok;
            if (pin_q.size() == 0) begin
                $error("unexpected pin word: nibble %0h rs %0d en %0d hold %0d",
                       got.nibble, got.rs, got.en, got.hold);
                fails++;
                return;
            end
            want = pin_q.pop_front();
            ok = 1'b1;
            ok &= field_ok("bus_nibble", want.nibble, got.nibble);
            ok &= field_ok("reg_select", want.rs, got.rs);
            ok &= field_ok("enable", want.en, got.en);
            ok &= field_ok("hold_ms", want.hold, got.hold);
            ok &= field_ok("overflow", want.ovf, got.ovf);
            ok &= field_ok("last", want.last, got.last);
            if (!ok) fails++;
        endfunction
    endclass

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [7:0]           i_cfg_data      = '0;
    logic                 i_in_valid      = 1'b0;
    logic [1:0]           i_req_type      = '0;
    logic [7:0]           i_byte_value    = '0;
    logic [15:0]          i_number_value  = '0;
    logic [2:0]           i_digit_count   = '0;
    logic                 i_decimal_point = 1'b0;
    logic                 i_out_ready     = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [3:0]           o_bus_nibble;
    logic                 o_reg_select;
    logic                 o_enable;
    logic [8:0]           o_hold_ms;
    logic                 o_overflow;
    logic                 o_last;

    lcd_scoreboard sb = new();

    // Shared knobs: written by the stimulus, read by the receiver and by pace_sender
    bit          in_calm    = 1'b0;
    bit          out_calm   = 1'b0;
    int unsigned hold_token = 0;

    int unsigned   hold_seen  = 0;
    int unsigned   stall_left = 0;
    lcd_pin_word_t rx_word;

    char_lcd_nibble_writer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_byte_value    (i_byte_value),
        .i_number_value  (i_number_value),
        .i_digit_count   (i_digit_count),
        .i_decimal_point (i_decimal_point),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_bus_nibble    (o_bus_nibble),
        .o_reg_select    (o_reg_select),
        .o_enable        (o_enable),
        .o_hold_ms       (o_hold_ms),
        .o_overflow      (o_overflow),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Check each accepted word, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rx_word.nibble = o_bus_nibble;
            rx_word.rs     = o_reg_select;
            rx_word.en     = o_enable;
            rx_word.hold   = o_hold_ms;
            rx_word.ovf    = o_overflow;
            rx_word.last   = o_last;
            sb.check_word(rx_word);
        end
        if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (out_calm) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 32);
        end
    end

    // Offer one request and hold it until the block takes it
    task automatic send_request(input lcd_req_t r);
        i_req_type      <= r.kind;
        i_byte_value    <= r.data_byte;
        i_number_value  <= r.num;
        i_digit_count   <= r.digits;
        i_decimal_point <= r.dot;
        i_in_valid      <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(r);
    endtask

    // Drop valid now and then for a random pause
    task automatic pace_sender();
        if (!in_calm && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait for every predicted word
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pin_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic program_regs(input logic [7:0] pulse, input logic [7:0] gap,
                                input bit spare);
        if (spare) write_reg(CFG_IDX_SPARE_A, 8'($urandom_range(255)));
        write_reg(CFG_PULSE_HOLD, pulse);
        write_reg(CFG_INIT_GAP, gap);
        if (spare) write_reg(CFG_IDX_SPARE_B, 8'($urandom_range(255)));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic lcd_req_t rand_request();
        lcd_req_t    r;
        int unsigned pick;
        int unsigned edges [9] = '{9, 10, 99, 100, 999, 1000, 9999, 10000, 65535};
        pick = $urandom_range(99);
        if (pick < 10) r.kind = REQ_INIT;
        else if (pick < 35) r.kind = REQ_CMD;
        else if (pick < 60) r.kind = REQ_DATA;
        else r.kind = REQ_NUM;
        r.data_byte = 8'($urandom_range(255));
        r.digits    = 3'($urandom_range(7));
        r.dot       = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:       r.num = 16'($urandom_range(99));
            1:       r.num = 16'($urandom_range(9999));
            2:       r.num = 16'($urandom_range(65535));
            default: r.num = 16'(edges[$urandom_range(8)]);
        endcase
        return r;
    endfunction

    initial begin
        lcd_req_t    dir_q[$];
        lcd_req_t    r;
        int unsigned ph;
        int unsigned k;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset register values
        dir_q.push_back('{REQ_INIT, 8'h00, 16'd0,     3'd0, 1'b0});
        dir_q.push_back('{REQ_CMD,  8'h00, 16'd0,     3'd0, 1'b0});
        dir_q.push_back('{REQ_CMD,  8'hFF, 16'hFFFF,  3'd7, 1'b1});
        dir_q.push_back('{REQ_DATA, 8'hA5, 16'd0,     3'd0, 1'b0});
        dir_q.push_back('{REQ_DATA, 8'h5A, 16'hFFFF,  3'd7, 1'b1});
        dir_q.push_back('{REQ_NUM,  8'hFF, 16'd0,     3'd0, 1'b0});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd7,     3'd1, 1'b1});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd99,    3'd2, 1'b0});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd100,   3'd2, 1'b1});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd999,   3'd3, 1'b1});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd1000,  3'd3, 1'b0});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd10000, 3'd4, 1'b1});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd65535, 3'd4, 1'b0});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd65535, 3'd5, 1'b1});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd0,     3'd5, 1'b0});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd12345, 3'd6, 1'b1});
        dir_q.push_back('{REQ_NUM,  8'h00, 16'd40960, 3'd7, 1'b0});
        dir_q.push_back('{REQ_INIT, 8'hFF, 16'hFFFF,  3'd7, 1'b1});
        foreach (dir_q[k]) begin
            send_request(dir_q[k]);
            pace_sender();
        end
        drain();

        // Random phases, each under its own register setting
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       program_regs(8'd0, 8'd0, 1'b0);
                1:       program_regs(8'd255, 8'd255, 1'b1);
                2:       program_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b0);
                3:       program_regs(8'd255, 8'd0, 1'b0);
                4:       program_regs(8'd0, 8'd255, 1'b1);
                default: program_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
            endcase
            out_calm = (ph == 1);
            in_calm  = (ph == 1);
            // Stall the receiver while requests keep coming back to back
            if (ph == 2) begin
                hold_token++;
                in_calm = 1'b1;
            end
            for (k = 0; k < 42; k++) begin
                if (ph == 2 && k == 10) in_calm = 1'b0;
                r = rand_request();
                send_request(r);
                pace_sender();
            end
            drain();
        end
        out_calm = 1'b0;
        in_calm  = 1'b0;
        repeat (20) @(posedge i_clk);

        if (sb.fails == 0 && sb.pin_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Hard stop if the block hangs
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/lcdnw_pkg.sv
rtl/core/lcdnw_ctrl.sv
rtl/core/lcdnw_dp.sv
rtl/core/char_lcd_nibble_writer_core.sv
rtl/core/lcdnw_chk.sv
tb/char_lcd_nibble_writer_core_tb.sv
